/* rtl/core/rv32ex_pkg.sv */
// ============================================================================
// rv32ex_pkg: shared definitions for the RV32 subset execute core
// Opcode and error codes, and the fixed constants of the instruction set.
// ============================================================================
package rv32ex_pkg;

    localparam int REG_COUNT  = 32;
    localparam int REG_IDX_W  = $clog2(REG_COUNT);
    localparam int XLEN       = 32;
    localparam int PLEN_W     = 16;

    // LUI/AUIPC place the immediate from bit 12 up; links are byte based.
    localparam int               UPPER_SHIFT = 12;
    localparam logic [XLEN-1:0]  LINK_OFFSET = 32'd4;
    localparam logic [XLEN-1:0]  ALIGN_MASK  = ~32'd1;

    typedef enum logic [4:0] {
        OP_NOP   = 5'd0,
        OP_ADD   = 5'd1,
        OP_ADDI  = 5'd2,
        OP_SUB   = 5'd3,
        OP_LI    = 5'd4,
        OP_SW    = 5'd5,
        OP_BEQ   = 5'd6,
        OP_BNE   = 5'd7,
        OP_BGE   = 5'd8,
        OP_BLT   = 5'd9,
        OP_MUL   = 5'd10,
        OP_LUI   = 5'd11,
        OP_AUIPC = 5'd12,
        OP_AND   = 5'd13,
        OP_OR    = 5'd14,
        OP_XOR   = 5'd15,
        OP_ANDI  = 5'd16,
        OP_SLL   = 5'd17,
        OP_SRL   = 5'd18,
        OP_SRA   = 5'd19,
        OP_SLLI  = 5'd20,
        OP_SRLI  = 5'd21,
        OP_SRAI  = 5'd22,
        OP_JALR  = 5'd23,
        OP_JAL   = 5'd24
    } opcode_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_X0_WRITE   = 2'd1,
        ERR_BAD_OPCODE = 2'd2
    } error_t;

endpackage

/* rtl/core/rv32_subset_execute_core_top.sv */
// ============================================================================
// rv32_subset_execute_core_top: RV32 subset execute core
// Pipeline: the accept edge registers the operands into the execute stage,
// and the execute stage then writes the result register when that register
// is empty or being taken.
// Throughput: one instruction word per cycle while the result side is not
// stalled; the register file write of one instruction is forwarded into the
// operand read of the next. Reset clears PC, halt flag, program length and
// the register file valid bits at once; there is no clearing pass.
// ============================================================================
module rv32_subset_execute_core_top (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_wr_en,
    input  logic [rv32ex_pkg::PLEN_W-1:0]      cfg_wr_data,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [4:0]                         s_opcode,
    input  logic [rv32ex_pkg::REG_IDX_W-1:0]   s_dest_reg,
    input  logic [rv32ex_pkg::REG_IDX_W-1:0]   s_src_one_reg,
    input  logic [rv32ex_pkg::REG_IDX_W-1:0]   s_src_two_reg,
    input  logic signed [rv32ex_pkg::XLEN-1:0] s_immediate,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rv32ex_pkg::XLEN-1:0]        m_next_pc,
    output logic                               m_halted,
    output logic [1:0]                         m_error_code,
    output logic                               m_store_valid,
    output logic [rv32ex_pkg::XLEN-1:0]        m_store_address,
    output logic [rv32ex_pkg::XLEN-1:0]        m_store_data
);

    localparam int XLEN  = rv32ex_pkg::XLEN;
    localparam int IDX_W = rv32ex_pkg::REG_IDX_W;
    localparam int NREG  = rv32ex_pkg::REG_COUNT;

    // Architectural state
    logic [XLEN-1:0]               pc_reg, pc_next;
    logic                          stopped_reg, stopped_next;
    logic [rv32ex_pkg::PLEN_W-1:0] prog_len_reg;

    // Register file: memory plus one valid bit per entry (invalid reads zero)
    logic [XLEN-1:0]               rf_mem [NREG];
    logic [NREG-1:0]               rf_valid_reg;

    // Execute stage
    logic                          ex_valid_reg;
    logic [4:0]                    ex_op_reg;
    logic [IDX_W-1:0]              ex_rd_reg;
    logic [XLEN-1:0]               ex_imm_reg;
    logic [XLEN-1:0]               opa_reg;
    logic [XLEN-1:0]               opb_reg;

    // Result register
    logic                          out_valid_reg;
    logic [XLEN-1:0]               out_pc_reg;
    logic                          out_halted_reg;
    logic [1:0]                    out_err_reg;
    logic                          out_st_valid_reg;
    logic [XLEN-1:0]               out_st_addr_reg;
    logic [XLEN-1:0]               out_st_data_reg;

    logic                          s_accept;
    logic                          ex_fire;
    logic [IDX_W-1:0]              rd_addr_b;

    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    logic [XLEN-1:0]               wr_data;

    logic [XLEN-1:0]               alu_res;
    logic                          alu_wb;
    logic [XLEN-1:0]               target;
    logic                          is_alu;
    rv32ex_pkg::error_t            err_next;
    logic                          st_valid_next;
    logic [XLEN-1:0]               st_addr_next;
    logic [XLEN-1:0]               st_data_next;
    logic                          commit;

    // ------------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------------
    assign ex_fire  = ex_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !ex_valid_reg || ex_fire;
    assign s_accept = s_valid && s_ready;

    // Branches and stores take their second operand from dest_reg.
    always_comb begin
        if (s_opcode inside {rv32ex_pkg::OP_SW, rv32ex_pkg::OP_BEQ, rv32ex_pkg::OP_BNE,
                             rv32ex_pkg::OP_BGE, rv32ex_pkg::OP_BLT}) begin
            rd_addr_b = s_dest_reg;
        end else begin
            rd_addr_b = s_src_two_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rf_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid_reg <= '0;
        end else if (wr_en) begin
            rf_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Operand read. A write landing on the same edge is forwarded.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (wr_en && wr_addr == s_src_one_reg) begin
                opa_reg <= wr_data;
            end else if (rf_valid_reg[s_src_one_reg]) begin
                opa_reg <= rf_mem[s_src_one_reg];
            end else begin
                opa_reg <= '0;
            end

            if (wr_en && wr_addr == rd_addr_b) begin
                opb_reg <= wr_data;
            end else if (rf_valid_reg[rd_addr_b]) begin
                opb_reg <= rf_mem[rd_addr_b];
            end else begin
                opb_reg <= '0;
            end

            ex_op_reg  <= s_opcode;
            ex_rd_reg  <= s_dest_reg;
            ex_imm_reg <= s_immediate;
        end
    end

    // ------------------------------------------------------------------------
    // Execute
    // ------------------------------------------------------------------------
    always_comb begin
        alu_res = '0;
        alu_wb  = 1'b0;
        target  = pc_reg;
        case (ex_op_reg)
            rv32ex_pkg::OP_ADD:   begin alu_res = opa_reg + opb_reg;   alu_wb = 1'b1; end
            rv32ex_pkg::OP_ADDI:  begin alu_res = opa_reg + ex_imm_reg; alu_wb = 1'b1; end
            rv32ex_pkg::OP_SUB:   begin alu_res = opa_reg - opb_reg;   alu_wb = 1'b1; end
            rv32ex_pkg::OP_LI:    begin alu_res = ex_imm_reg;          alu_wb = 1'b1; end
            rv32ex_pkg::OP_MUL:   begin alu_res = opa_reg * opb_reg;   alu_wb = 1'b1; end
            rv32ex_pkg::OP_LUI: begin
                alu_res = ex_imm_reg << rv32ex_pkg::UPPER_SHIFT;
                alu_wb  = 1'b1;
            end
            rv32ex_pkg::OP_AUIPC: begin
                alu_res = pc_reg + (ex_imm_reg << rv32ex_pkg::UPPER_SHIFT);
                alu_wb  = 1'b1;
            end
            rv32ex_pkg::OP_AND:   begin alu_res = opa_reg & opb_reg;    alu_wb = 1'b1; end
            rv32ex_pkg::OP_OR:    begin alu_res = opa_reg | opb_reg;    alu_wb = 1'b1; end
            rv32ex_pkg::OP_XOR:   begin alu_res = opa_reg ^ opb_reg;    alu_wb = 1'b1; end
            rv32ex_pkg::OP_ANDI:  begin alu_res = opa_reg & ex_imm_reg; alu_wb = 1'b1; end
            rv32ex_pkg::OP_SLL:   begin alu_res = opa_reg << opb_reg[4:0]; alu_wb = 1'b1; end
            rv32ex_pkg::OP_SRL:   begin alu_res = opa_reg >> opb_reg[4:0]; alu_wb = 1'b1; end
            rv32ex_pkg::OP_SRA: begin
                alu_res = $unsigned($signed(opa_reg) >>> opb_reg[4:0]);
                alu_wb  = 1'b1;
            end
            rv32ex_pkg::OP_SLLI:  begin alu_res = opa_reg << ex_imm_reg[4:0]; alu_wb = 1'b1; end
            rv32ex_pkg::OP_SRLI:  begin alu_res = opa_reg >> ex_imm_reg[4:0]; alu_wb = 1'b1; end
            rv32ex_pkg::OP_SRAI: begin
                alu_res = $unsigned($signed(opa_reg) >>> ex_imm_reg[4:0]);
                alu_wb  = 1'b1;
            end
            rv32ex_pkg::OP_BEQ: begin
                if (opb_reg == opa_reg) target = pc_reg + ex_imm_reg;
            end
            rv32ex_pkg::OP_BNE: begin
                if (opb_reg != opa_reg) target = pc_reg + ex_imm_reg;
            end
            rv32ex_pkg::OP_BGE: begin
                if ($signed(opb_reg) >= $signed(opa_reg)) target = pc_reg + ex_imm_reg;
            end
            rv32ex_pkg::OP_BLT: begin
                if ($signed(opb_reg) < $signed(opa_reg)) target = pc_reg + ex_imm_reg;
            end
            rv32ex_pkg::OP_JALR: begin
                alu_res = pc_reg + rv32ex_pkg::LINK_OFFSET;
                alu_wb  = 1'b1;
                target  = (opa_reg + ex_imm_reg) & rv32ex_pkg::ALIGN_MASK;
            end
            rv32ex_pkg::OP_JAL: begin
                alu_res = pc_reg + rv32ex_pkg::LINK_OFFSET;
                alu_wb  = 1'b1;
                target  = pc_reg + ex_imm_reg;
            end
            default: begin
                alu_res = '0;
                alu_wb  = 1'b0;
                target  = pc_reg;
            end
        endcase
    end

    assign is_alu = ex_op_reg inside {
        rv32ex_pkg::OP_ADD, rv32ex_pkg::OP_ADDI, rv32ex_pkg::OP_SUB, rv32ex_pkg::OP_LI,
        rv32ex_pkg::OP_MUL, rv32ex_pkg::OP_AND, rv32ex_pkg::OP_OR, rv32ex_pkg::OP_XOR,
        rv32ex_pkg::OP_ANDI, rv32ex_pkg::OP_SLL, rv32ex_pkg::OP_SRL, rv32ex_pkg::OP_SRA,
        rv32ex_pkg::OP_SLLI, rv32ex_pkg::OP_SRLI, rv32ex_pkg::OP_SRAI};

    // Halt checks in priority order, then the normal commit.
    always_comb begin
        pc_next       = pc_reg;
        stopped_next  = stopped_reg;
        err_next      = rv32ex_pkg::ERR_NONE;
        st_valid_next = 1'b0;
        st_addr_next  = '0;
        st_data_next  = '0;
        commit        = 1'b0;
        if (!stopped_reg) begin
            if (pc_reg >= {{(XLEN-rv32ex_pkg::PLEN_W){1'b0}}, prog_len_reg} ||
                ex_op_reg == rv32ex_pkg::OP_NOP) begin
                stopped_next = 1'b1;
            end else if (ex_op_reg > rv32ex_pkg::OP_JAL) begin
                stopped_next = 1'b1;
                err_next     = rv32ex_pkg::ERR_BAD_OPCODE;
            end else if (ex_rd_reg == '0 && is_alu) begin
                stopped_next = 1'b1;
                err_next     = rv32ex_pkg::ERR_X0_WRITE;
            end else begin
                commit = 1'b1;
                if (target == pc_reg) begin
                    pc_next = pc_reg + XLEN'(1);
                end else begin
                    pc_next = target;
                end
                if (ex_op_reg == rv32ex_pkg::OP_SW) begin
                    st_valid_next = 1'b1;
                    st_addr_next  = ex_imm_reg + opa_reg;
                    st_data_next  = opb_reg;
                end
            end
        end
    end

    // Writes to x0 are dropped here, so entry zero never becomes valid.
    assign wr_en   = ex_fire && commit && alu_wb && (ex_rd_reg != '0);
    assign wr_addr = ex_rd_reg;
    assign wr_data = alu_res;

    // ------------------------------------------------------------------------
    // State, pipeline control and result register
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= '0;
            stopped_reg   <= 1'b0;
            prog_len_reg  <= '0;
            ex_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                prog_len_reg <= cfg_wr_data;
            end
            if (s_accept) begin
                ex_valid_reg <= 1'b1;
            end else if (ex_fire) begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_fire) begin
                pc_reg        <= pc_next;
                stopped_reg   <= stopped_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ex_fire) begin
            out_pc_reg       <= pc_next;
            out_halted_reg   <= stopped_next;
            out_err_reg      <= err_next;
            out_st_valid_reg <= st_valid_next;
            out_st_addr_reg  <= st_addr_next;
            out_st_data_reg  <= st_data_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_next_pc       = out_pc_reg;
    assign m_halted        = out_halted_reg;
    assign m_error_code    = out_err_reg;
    assign m_store_valid   = out_st_valid_reg;
    assign m_store_address = out_st_addr_reg;
    assign m_store_data    = out_st_data_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_no_x0_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> wr_addr != '0)
        else $error("register x0 written");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg)
        else $error("halt flag cleared without reset");

    a_pc_only_on_execute: assert property (@(posedge aclk) disable iff (!aresetn)
        !ex_fire |=> $stable(pc_reg))
        else $error("PC changed without an executed word");

    a_error_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error_code != rv32ex_pkg::ERR_NONE) |-> m_halted)
        else $error("error reported on a running core");

    a_store_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_store_valid) |-> (!m_halted && m_error_code == rv32ex_pkg::ERR_NONE))
        else $error("store issued by a halted or failing word");

endmodule

/* verif/rv32_subset_execute_core_top_test.sv */
// ============================================================================
// rv32_subset_execute_core_top_test: regression bench for the execute core
// Sends decoded instruction words through the valid/ready input channel and
// checks every result word against an in-bench model of the core. A short
// table of directed words comes first, then phases of random programs under
// several program lengths. The run ends with the core halted on purpose,
// followed by a few words that it must ignore.
// ============================================================================
module rv32_subset_execute_core_top_test;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_WORDS    = 200;
    localparam int PHASE_COUNT    = 6;
    localparam int DIR_N          = 29;

    typedef struct packed {
        logic [4:0]  op;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
    } instr_t;

    typedef struct packed {
        logic [31:0]        next_pc;
        logic               halted;
        rv32ex_pkg::error_t err;
        logic               st_valid;
        logic [31:0]        st_addr;
        logic [31:0]        st_data;
    } result_t;

    typedef struct packed {
        logic [31:0][31:0] regs;
        logic [31:0]       pc;
        logic              stopped;
    } core_state_t;

    // Directed words. Where typed is set, the expected result is given here.
    typedef struct packed {
        logic [4:0]  op;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic        typed;
        logic [31:0] want_pc;
        logic        want_sv;
        logic [31:0] want_sa;
        logic [31:0] want_sd;
    } dir_row_t;

    localparam dir_row_t DIR_TAB [DIR_N] = '{
        '{rv32ex_pkg::OP_LI, 5'd1, 5'd0, 5'd0, 32'h7fffffff, 1'b1, 32'd1, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_LI, 5'd2, 5'd0, 5'd0, 32'h80000000, 1'b1, 32'd2, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_ADD, 5'd3, 5'd1, 5'd2, 32'h00000000, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_ADDI, 5'd4, 5'd1, 5'd0, 32'h00000001, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_SUB, 5'd5, 5'd2, 5'd1, 32'h00000000, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_MUL, 5'd6, 5'd1, 5'd1, 32'h00000000, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_SW, 5'd2, 5'd1, 5'd0, 32'h7fffffff, 1'b1, 32'd7, 1'b1,
          32'hfffffffe, 32'h80000000},
        '{rv32ex_pkg::OP_SW, 5'd3, 5'd3, 5'd0, 32'h00000001, 1'b1, 32'd8, 1'b1,
          32'h00000000, 32'hffffffff},
        '{rv32ex_pkg::OP_LUI, 5'd7, 5'd0, 5'd0, 32'h000fffff, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_AUIPC, 5'd8, 5'd0, 5'd0, 32'hffffffff, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_LUI, 5'd0, 5'd0, 5'd0, 32'h00000005, 1'b1, 32'd11, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_AND, 5'd9, 5'd3, 5'd2, 32'h00000000, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_OR, 5'd10, 5'd1, 5'd2, 32'h00000000, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_XOR, 5'd11, 5'd3, 5'd1, 32'h00000000, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_ANDI, 5'd12, 5'd3, 5'd0, 32'h0f0f0f0f, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_LI, 5'd14, 5'd0, 5'd0, 32'd35, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_SLL, 5'd13, 5'd3, 5'd14, 32'h00000000, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_SRL, 5'd15, 5'd2, 5'd14, 32'h00000000, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_SRA, 5'd16, 5'd2, 5'd14, 32'h00000000, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_SLLI, 5'd17, 5'd1, 5'd0, 32'hffffffff, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_SRLI, 5'd18, 5'd3, 5'd0, 32'h0000003f, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_SRAI, 5'd19, 5'd2, 5'd0, 32'hffffffe1, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_BEQ, 5'd1, 5'd1, 5'd0, 32'h00000000, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_BNE, 5'd1, 5'd2, 5'd0, 32'h00000002, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_BGE, 5'd1, 5'd2, 5'd0, 32'hfffffffd, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_BLT, 5'd1, 5'd2, 5'd0, 32'h80000000, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_JAL, 5'd0, 5'd0, 5'd0, 32'h00000005, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_JALR, 5'd20, 5'd20, 5'd0, 32'h00000007, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{rv32ex_pkg::OP_JALR, 5'd21, 5'd20, 5'd0, 32'h00000001, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0}
    };

    logic        aclk;
    logic        aresetn         = 1'b0;
    logic        cfg_wr_en       = 1'b0;
    logic [15:0] cfg_wr_data     = '0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [4:0]  s_opcode        = '0;
    logic [4:0]  s_dest_reg      = '0;
    logic [4:0]  s_src_one_reg   = '0;
    logic [4:0]  s_src_two_reg   = '0;
    logic [31:0] s_immediate     = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [31:0] m_next_pc;
    logic        m_halted;
    logic [1:0]  m_error_code;
    logic        m_store_valid;
    logic [31:0] m_store_address;
    logic [31:0] m_store_data;

    core_state_t cpu;
    logic [15:0] prog_len;
    result_t     pending_results [$];

    int fail_count     = 0;
    int words_sent     = 0;
    int results_seen   = 0;
    int len_settings   = 0;
    int idle_cycles    = 0;
    int stall_left     = 0;
    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    bit quiet_tail     = 1'b0;

    rv32_subset_execute_core_top uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_dest_reg      (s_dest_reg),
        .s_src_one_reg   (s_src_one_reg),
        .s_src_two_reg   (s_src_two_reg),
        .s_immediate     (s_immediate),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_next_pc       (m_next_pc),
        .m_halted        (m_halted),
        .m_error_code    (m_error_code),
        .m_store_valid   (m_store_valid),
        .m_store_address (m_store_address),
        .m_store_data    (m_store_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit is_alu_write(input logic [4:0] op);
        case (op)
            rv32ex_pkg::OP_ADD, rv32ex_pkg::OP_ADDI, rv32ex_pkg::OP_SUB, rv32ex_pkg::OP_LI,
            rv32ex_pkg::OP_MUL, rv32ex_pkg::OP_AND, rv32ex_pkg::OP_OR, rv32ex_pkg::OP_XOR,
            rv32ex_pkg::OP_ANDI, rv32ex_pkg::OP_SLL, rv32ex_pkg::OP_SRL, rv32ex_pkg::OP_SRA,
            rv32ex_pkg::OP_SLLI, rv32ex_pkg::OP_SRLI, rv32ex_pkg::OP_SRAI: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Executes one instruction word on the given core state and returns the
    // result word the core should deliver for it.
    function automatic result_t retire_word(inout core_state_t st, input instr_t w);
        result_t     r;
        logic [31:0] a, b, d, pc, npc, wval;
        logic        wen;
        r  = '0;
        a  = st.regs[w.rs1];
        b  = st.regs[w.rs2];
        d  = st.regs[w.rd];
        pc = st.pc;
        if (!st.stopped) begin
            if (pc >= 32'(prog_len) || w.op == rv32ex_pkg::OP_NOP) begin
                st.stopped = 1'b1;
            end else if (w.op > rv32ex_pkg::OP_JAL) begin
                st.stopped = 1'b1;
                r.err = rv32ex_pkg::ERR_BAD_OPCODE;
            end else if (w.rd == '0 && is_alu_write(w.op)) begin
                st.stopped = 1'b1;
                r.err = rv32ex_pkg::ERR_X0_WRITE;
            end else begin
                npc  = pc;
                wen  = 1'b1;
                wval = '0;
                case (w.op)
                    rv32ex_pkg::OP_ADD:   wval = a + b;
                    rv32ex_pkg::OP_ADDI:  wval = a + w.imm;
                    rv32ex_pkg::OP_SUB:   wval = a - b;
                    rv32ex_pkg::OP_LI:    wval = w.imm;
                    rv32ex_pkg::OP_MUL:   wval = a * b;
                    rv32ex_pkg::OP_LUI:   wval = w.imm << rv32ex_pkg::UPPER_SHIFT;
                    rv32ex_pkg::OP_AUIPC: wval = pc + (w.imm << rv32ex_pkg::UPPER_SHIFT);
                    rv32ex_pkg::OP_AND:   wval = a & b;
                    rv32ex_pkg::OP_OR:    wval = a | b;
                    rv32ex_pkg::OP_XOR:   wval = a ^ b;
                    rv32ex_pkg::OP_ANDI:  wval = a & w.imm;
                    rv32ex_pkg::OP_SLL:   wval = a << b[4:0];
                    rv32ex_pkg::OP_SRL:   wval = a >> b[4:0];
                    rv32ex_pkg::OP_SRA:   wval = $signed(a) >>> b[4:0];
                    rv32ex_pkg::OP_SLLI:  wval = a << w.imm[4:0];
                    rv32ex_pkg::OP_SRLI:  wval = a >> w.imm[4:0];
                    rv32ex_pkg::OP_SRAI:  wval = $signed(a) >>> w.imm[4:0];
                    rv32ex_pkg::OP_JALR: begin
                        // The target uses the base read before the link lands.
                        wval = pc + rv32ex_pkg::LINK_OFFSET;
                        npc  = (a + w.imm) & rv32ex_pkg::ALIGN_MASK;
                    end
                    rv32ex_pkg::OP_JAL: begin
                        wval = pc + rv32ex_pkg::LINK_OFFSET;
                        npc  = pc + w.imm;
                    end
                    rv32ex_pkg::OP_SW: begin
                        wen        = 1'b0;
                        r.st_valid = 1'b1;
                        r.st_addr  = w.imm + a;
                        r.st_data  = d;
                    end
                    rv32ex_pkg::OP_BEQ: begin
                        wen = 1'b0;
                        if (d == a) npc = pc + w.imm;
                    end
                    rv32ex_pkg::OP_BNE: begin
                        wen = 1'b0;
                        if (d != a) npc = pc + w.imm;
                    end
                    rv32ex_pkg::OP_BGE: begin
                        wen = 1'b0;
                        if ($signed(d) >= $signed(a)) npc = pc + w.imm;
                    end
                    default: begin
                        wen = 1'b0;
                        if ($signed(d) < $signed(a)) npc = pc + w.imm;
                    end
                endcase
                if (wen && w.rd != '0) st.regs[w.rd] = wval;
                if (npc == pc) npc = pc + 1;
                st.pc = npc;
            end
        end
        r.next_pc = st.pc;
        r.halted  = st.stopped;
        return r;
    endfunction

    // Half the picks come from a small pool so that words depend on each other.
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 1) != 0) return 5'($urandom_range(1, 7));
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [31:0] pick_imm();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 127) - 32'd64;
            2: begin
                case ($urandom_range(0, 4))
                    0: return 32'h00000000;
                    1: return 32'h00000001;
                    2: return 32'hffffffff;
                    3: return 32'h7fffffff;
                    default: return 32'h80000000;
                endcase
            end
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    // An unconditional jump from the current PC to target, with a random link.
    function automatic instr_t jump_to(input logic [31:0] target);
        instr_t w;
        w.op  = rv32ex_pkg::OP_JAL;
        w.rd  = pick_reg();
        w.rs1 = pick_reg();
        w.rs2 = pick_reg();
        w.imm = target - cpu.pc;
        return w;
    endfunction

    // A random word that keeps the core running inside the program.
    function automatic instr_t gen_word();
        instr_t      w;
        core_state_t trial;
        logic [31:0] target;
        for (int k = 0; k < 16; k++) begin
            w.op  = 5'($urandom_range(rv32ex_pkg::OP_ADD, rv32ex_pkg::OP_JAL));
            w.rd  = pick_reg();
            w.rs1 = pick_reg();
            w.rs2 = pick_reg();
            w.imm = pick_imm();
            if (((w.op >= rv32ex_pkg::OP_BEQ && w.op <= rv32ex_pkg::OP_BLT) ||
                 w.op == rv32ex_pkg::OP_JAL || w.op == rv32ex_pkg::OP_JALR)
                && $urandom_range(0, 9) < 7) begin
                target = $urandom_range(0, prog_len - 1);
                w.imm  = target - ((w.op == rv32ex_pkg::OP_JALR) ? cpu.regs[w.rs1] : cpu.pc);
            end
            trial = cpu;
            void'(retire_word(trial, w));
            if (!trial.stopped && trial.pc < 32'(prog_len)) return w;
        end
        target = $urandom_range(0, prog_len - 1);
        if (target == cpu.pc) target = (cpu.pc == 0) ? 32'd1 : 32'd0;
        return jump_to(target);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < 40)
            $display("MISMATCH %s: got %h, expected %h (result word %0d)",
                     what, got, want, results_seen);
        fail_count++;
    endtask

    task automatic send_word(input instr_t w, input result_t want);
        int gap;
        if (!quiet_tail && $urandom_range(0, 99) < src_gap_pct) begin
            gap = $urandom_range(1, 13);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= w.op;
        s_dest_reg    <= w.rd;
        s_src_one_reg <= w.rs1;
        s_src_two_reg <= w.rs2;
        s_immediate   <= w.imm;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_results.push_back(want);
        words_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic set_prog_len(input logic [15:0] len);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        prog_len = len;
        len_settings++;
    endtask

    // Result side: random stall bursts, none started in the quiet tail.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 99) < sink_stall_pct) begin
            stall_left <= $urandom_range(0, 12);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing pending", m_next_pc, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_next_pc !== want.next_pc)
                    report_mismatch("next_pc", m_next_pc, want.next_pc);
                if (m_halted !== want.halted)
                    report_mismatch("halted", 32'(m_halted), 32'(want.halted));
                if (m_error_code !== want.err)
                    report_mismatch("error_code", 32'(m_error_code), 32'(want.err));
                if (m_store_valid !== want.st_valid)
                    report_mismatch("store_valid", 32'(m_store_valid), 32'(want.st_valid));
                if (m_store_address !== want.st_addr)
                    report_mismatch("store_address", m_store_address, want.st_addr);
                if (m_store_data !== want.st_data)
                    report_mismatch("store_data", m_store_data, want.st_data);
                results_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("rv32_subset_execute_core_top regression: fail");
        $finish;
    end

    initial begin
        instr_t      w;
        result_t     want;
        logic [15:0] len_plan [PHASE_COUNT];
        int          cause;
        int          ignored;
        string       cause_name;

        cpu      = '0;
        prog_len = '0;
        ignored  = 0;
        len_plan = '{16'hffff, 16'd2, 16'd3, 16'($urandom_range(4, 40)),
                     16'($urandom_range(41, 65535)), 16'd100};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_prog_len(16'hffff);
        src_gap_pct    = 25;
        sink_stall_pct = 25;
        for (int i = 0; i < DIR_N; i++) begin
            w    = '{DIR_TAB[i].op, DIR_TAB[i].rd, DIR_TAB[i].rs1, DIR_TAB[i].rs2,
                     DIR_TAB[i].imm};
            want = retire_word(cpu, w);
            if (DIR_TAB[i].typed)
                want = '{DIR_TAB[i].want_pc, 1'b0, rv32ex_pkg::ERR_NONE, DIR_TAB[i].want_sv,
                         DIR_TAB[i].want_sa, DIR_TAB[i].want_sd};
            send_word(w, want);
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            // Return to the start so the PC fits under the next program length.
            w    = jump_to(32'd0);
            want = retire_word(cpu, w);
            send_word(w, want);
            wait_drained();
            set_prog_len(len_plan[p]);
            case ($urandom_range(0, 2))
                0: src_gap_pct = 0;
                1: src_gap_pct = 10;
                default: src_gap_pct = 35;
            endcase
            case ($urandom_range(0, 2))
                0: sink_stall_pct = 0;
                1: sink_stall_pct = 10;
                default: sink_stall_pct = 35;
            endcase
            if (p == PHASE_COUNT - 1) quiet_tail = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                w    = gen_word();
                want = retire_word(cpu, w);
                send_word(w, want);
            end
        end

        // Halt the core once, by one randomly chosen cause.
        wait_drained();
        cause = $urandom_range(0, 3);
        w.rd  = pick_reg();
        w.rs1 = pick_reg();
        w.rs2 = pick_reg();
        w.imm = pick_imm();
        case (cause)
            0: begin
                w.op = rv32ex_pkg::OP_NOP;
                cause_name = "a NOP";
            end
            1: begin
                w.op = 5'($urandom_range(25, 31));
                cause_name = "an unknown opcode";
            end
            2: begin
                do w.op = 5'($urandom_range(rv32ex_pkg::OP_ADD, rv32ex_pkg::OP_SRAI));
                while (!is_alu_write(w.op));
                w.rd = '0;
                cause_name = "an ALU write to x0";
            end
            default: begin
                w.op = 5'($urandom_range(0, 31));
                set_prog_len(16'd0);
                cause_name = "a PC outside the program";
            end
        endcase
        want = retire_word(cpu, w);
        send_word(w, want);

        for (int n = 0; n < 8; n++) begin
            if (n == 6) begin
                wait_drained();
                if (cause != 3) set_prog_len(16'd0);
            end
            w    = '{5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                     5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), $urandom};
            want = retire_word(cpu, w);
            send_word(w, want);
            ignored++;
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch("result words never delivered", pending_results.size(), 0);

        $display("Sent %0d instruction words (%0d from the directed table) under %0d",
                 words_sent, DIR_N, len_settings);
        $display("program-length settings; %0d result words checked, halt by %s, %0d ignored.",
                 results_seen, cause_name, ignored);
        if (fail_count == 0) begin
            $display("rv32_subset_execute_core_top regression: pass");
        end else begin
            $display("rv32_subset_execute_core_top regression: fail");
        end
        $finish;
    end

endmodule
